// File: hw/rtl/rtc_pkg.sv
// Shared types and constants for the real-time clock and calendar counter.
// Holds the payload structs, opcodes, register indexes and calendar helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int RES25_W  = 5;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_HOUR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_MINUTE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_SECOND = 2'd2;

    localparam logic [SECOND_W-1:0] SECOND_LAST = 6'd59;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
    localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
    localparam logic [MONTH_W-1:0]  MONTH_LAST  = 4'd12;
    localparam logic [YEAR_W-1:0]   YEAR_LAST   = 14'd9999;

    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;
    // 2000 mod 25
    localparam logic [RES25_W-1:0] RESET_RES25 = 5'd0;
    localparam logic [RES25_W-1:0] RES25_LAST  = 5'd24;

    // floor(y / 25) == (y * YEAR_RECIP) >> YEAR_SHIFT for every 14-bit y
    localparam int YEAR_RECIP = 10486;
    localparam int YEAR_SHIFT = 18;
    localparam int PROD_W     = 2 * YEAR_W;
    localparam int QUOT_W     = PROD_W - YEAR_SHIFT;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } rtc_op_t;

    typedef struct packed {
        rtc_op_t              opcode;
        logic [HOUR_W-1:0]    load_hour;
        logic [MINUTE_W-1:0]  load_minute;
        logic [SECOND_W-1:0]  load_second;
        logic [DAY_W-1:0]     load_day;
        logic [MONTH_W-1:0]   load_month;
        logic [YEAR_W-1:0]    load_year;
    } rtc_in_t;

    typedef struct packed {
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
        logic [SECOND_W-1:0]  second;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
        logic                 alarm_match;
        logic                 date_advanced;
    } rtc_out_t;

    // Year modulo 25 by reciprocal multiply; the quotient is exact over 14 bits.
    function automatic logic [RES25_W-1:0] year_mod25(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        logic [YEAR_W-1:0] q_ext;
        logic [YEAR_W-1:0] q_times25;
        logic [YEAR_W-1:0] rem;
        prod      = PROD_W'(y) * PROD_W'(YEAR_RECIP);
        quot      = prod[PROD_W-1:YEAR_SHIFT];
        q_ext     = YEAR_W'(quot);
        q_times25 = (q_ext << 4) + (q_ext << 3) + q_ext;
        rem       = y - q_times25;
        return rem[RES25_W-1:0];
    endfunction

    // Gregorian rule: divisible by 4 and not by 100, or by 400.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                     input logic [RES25_W-1:0] res25);
        return (y[1:0] == 2'b00) && ((res25 != '0) || (y[3:0] == 4'b0000));
    endfunction

    // Month length; months outside 1..12 count as 31 days.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rtc_time_calendar_counter.sv
// Real-time clock and calendar counter with alarm compare, top level.
// Depends on rtc_pkg for payload structs, opcodes and calendar helpers.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one item per
//   transfer: a one-second tick or a load of the full time and date.
//   Every input transfer yields exactly one result on the output channel
//   (out_valid, out_stall, out_data): time and date after the step, an alarm
//   flag and a date-advanced flag.
//   Each item is registered first in the input register, then in the result
//   register. Throughput: one item per cycle unless the receiver stalls;
//   the calendar update is a single pass of logic from the input register
//   to the state and result registers.
//   The alarm time is written through cfg_wen / cfg_index / cfg_wdata while
//   the block is idle, a rule for the user that the block itself does not
//   enforce; writes to unused indexes are dropped. Reset clears both stages
//   and sets the time to 00:00:00 on 1/1/2000 with the alarm at 00:00:00.
//   When the receiver stalls, the result register holds; the input register
//   still fills, and in_stall rises only when both stages are occupied.
`timescale 1ns / 1ps
`default_nettype none

module rtc_time_calendar_counter (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output      logic                                   in_stall,
    input  wire rtc_pkg::rtc_in_t                       in_data,
    output      logic                                   out_valid,
    input  wire logic                                   out_stall,
    output      rtc_pkg::rtc_out_t                      out_data,
    input  wire logic                                   cfg_wen,
    input  wire logic [rtc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [rtc_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
    import rtc_pkg::*;

    // alarm registers
    logic [HOUR_W-1:0]   alarm_hour_reg;
    logic [MINUTE_W-1:0] alarm_minute_reg;
    logic [SECOND_W-1:0] alarm_second_reg;

    // input stage
    logic                s1_valid_reg;
    rtc_in_t             s1_data_reg;
    logic [RES25_W-1:0]  s1_res25_reg;
    logic                s1_load;
    logic                s2_advance;

    // clock and calendar state
    logic [HOUR_W-1:0]   hour_reg,   hour_next;
    logic [MINUTE_W-1:0] minute_reg, minute_next;
    logic [SECOND_W-1:0] second_reg, second_next;
    logic [DAY_W-1:0]    day_reg,    day_next;
    logic [MONTH_W-1:0]  month_reg,  month_next;
    logic [YEAR_W-1:0]   year_reg,   year_next;
    logic [RES25_W-1:0]  res25_reg,  res25_next;
    logic                advanced_next;
    logic                alarm_next;

    // result stage
    logic                out_valid_reg;
    rtc_out_t            out_data_reg;

    assign s2_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_load    = !s1_valid_reg || s2_advance;
    assign in_stall   = !s1_load;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            alarm_hour_reg   <= '0;
            alarm_minute_reg <= '0;
            alarm_second_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_ALARM_HOUR:   alarm_hour_reg   <= cfg_wdata[HOUR_W-1:0];
                CFG_ALARM_MINUTE: alarm_minute_reg <= cfg_wdata[MINUTE_W-1:0];
                CFG_ALARM_SECOND: alarm_second_reg <= cfg_wdata[SECOND_W-1:0];
                default:          ;
            endcase
        end
    end

    // input register; the year residue for a load is found here
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_load && in_valid)
        begin
            s1_data_reg  <= in_data;
            s1_res25_reg <= year_mod25(in_data.load_year);
        end
    end

    always_comb begin
        logic             sec_wrap;
        logic             min_wrap;
        logic             hour_wrap;
        logic [DAY_W-1:0] len;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        res25_next    = res25_reg;
        advanced_next = 1'b0;
        sec_wrap      = second_reg >= SECOND_LAST;
        min_wrap      = minute_reg >= MINUTE_LAST;
        hour_wrap     = hour_reg >= HOUR_LAST;
        len           = month_days(month_reg, is_leap(year_reg, res25_reg));

        unique case (s1_data_reg.opcode)
            OP_LOAD:
            begin
                hour_next   = s1_data_reg.load_hour;
                minute_next = s1_data_reg.load_minute;
                second_next = s1_data_reg.load_second;
                day_next    = s1_data_reg.load_day;
                month_next  = s1_data_reg.load_month;
                year_next   = s1_data_reg.load_year;
                res25_next  = s1_res25_reg;
            end
            OP_TICK:
            begin
                second_next = sec_wrap ? '0 : second_reg + 1'b1;
                if (sec_wrap)
                begin
                    minute_next = min_wrap ? '0 : minute_reg + 1'b1;
                end
                if (sec_wrap && min_wrap)
                begin
                    hour_next = hour_wrap ? '0 : hour_reg + 1'b1;
                end
                if (sec_wrap && min_wrap && hour_wrap)
                begin
                    advanced_next = 1'b1;
                    if (day_reg >= len)
                    begin
                        day_next = RESET_DAY;
                        if (month_reg >= MONTH_LAST)
                        begin
                            // roll into January of the next year
                            month_next = RESET_MONTH;
                            if (year_reg >= YEAR_LAST)
                            begin
                                year_next  = '0;
                                res25_next = '0;
                            end
                            else
                            begin
                                year_next  = year_reg + 1'b1;
                                res25_next = (res25_reg >= RES25_LAST) ? '0
                                                                       : res25_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            month_next = month_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        day_next = day_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase

        alarm_next = (hour_next == alarm_hour_reg) && (minute_next == alarm_minute_reg)
                     && (second_next == alarm_second_reg);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            day_reg    <= RESET_DAY;
            month_reg  <= RESET_MONTH;
            year_reg   <= RESET_YEAR;
            res25_reg  <= RESET_RES25;
        end
        else if (s2_advance)
        begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            res25_reg  <= res25_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= s2_advance || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk) begin
        if (s2_advance)
        begin
            out_data_reg.hour          <= hour_next;
            out_data_reg.minute        <= minute_next;
            out_data_reg.second        <= second_next;
            out_data_reg.day           <= day_next;
            out_data_reg.month         <= month_next;
            out_data_reg.year          <= year_next;
            out_data_reg.alarm_match   <= alarm_next;
            out_data_reg.date_advanced <= advanced_next;
        end
    end

    // Input backs up only when both stages are full and the receiver stalls.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with a free stage");

    // The year residue, which tracks the year, stays a valid residue.
    a_res25_range: assert property (@(posedge clk) disable iff (!rst_n)
        res25_reg <= RES25_LAST)
        else $error("year residue out of range");

    // A date advance only happens on a rollover to midnight.
    a_midnight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.date_advanced) |->
            (out_data_reg.hour == '0 && out_data_reg.minute == '0
             && out_data_reg.second == '0))
        else $error("date advanced away from midnight");

    // An advanced date never lands on day zero.
    a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.date_advanced) |-> (out_data_reg.day != '0))
        else $error("date advance produced day zero");

endmodule

`default_nettype wire

// File: tb/sv/tb_rtc_calendar_checker.sv
// Result checker for the calendar counter: keeps its own copy of the clock,
// the date and the alarm registers, and predicts one result per input transfer.
// Depends on rtc_pkg for the payload structs, opcodes and register indexes.
`timescale 1ns / 1ps

module tb_rtc_calendar_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  rtc_pkg::rtc_in_t                  in_data,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  rtc_pkg::rtc_out_t                 out_data,
    input  logic                              cfg_wen,
    input  logic [rtc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rtc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output int                                error_count,
    output int                                pending,
    output int                                checked,
    output int                                rollovers,
    output int                                alarm_hits
);
    import rtc_pkg::*;

    localparam int unsigned MONTH_LEN [0:11] = '{31, 28, 31, 30, 31, 30,
                                                 31, 31, 30, 31, 30, 31};

    logic [HOUR_W-1:0]   cur_hour;
    logic [MINUTE_W-1:0] cur_minute;
    logic [SECOND_W-1:0] cur_second;
    logic [DAY_W-1:0]    cur_day;
    logic [MONTH_W-1:0]  cur_month;
    logic [YEAR_W-1:0]   cur_year;

    logic [HOUR_W-1:0]   alarm_hour;
    logic [MINUTE_W-1:0] alarm_minute;
    logic [SECOND_W-1:0] alarm_second;

    rtc_out_t results_due[$];

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        if (m == 0 || m > 12)
            return 31;
        if (m == 2 && leap_year(y))
            return 29;
        return MONTH_LEN[m-1];
    endfunction

    // Apply one tick or load to the local clock state and return its result.
    function automatic rtc_out_t step_calendar(input rtc_in_t item);
        rtc_out_t res;
        logic     rolled;
        rolled = 1'b0;
        if (item.opcode == OP_LOAD)
        begin
            cur_hour   = item.load_hour;
            cur_minute = item.load_minute;
            cur_second = item.load_second;
            cur_day    = item.load_day;
            cur_month  = item.load_month;
            cur_year   = item.load_year;
        end
        else if (cur_second < SECOND_LAST)
            cur_second++;
        else
        begin
            cur_second = '0;
            if (cur_minute < MINUTE_LAST)
                cur_minute++;
            else
            begin
                cur_minute = '0;
                if (cur_hour < HOUR_LAST)
                    cur_hour++;
                else
                begin
                    // midnight: advance the date
                    cur_hour = '0;
                    rolled   = 1'b1;
                    if (cur_day >= month_length(cur_month, cur_year))
                    begin
                        cur_day = DAY_W'(1);
                        if (cur_month >= MONTH_LAST)
                        begin
                            cur_month = MONTH_W'(1);
                            cur_year  = (cur_year >= YEAR_LAST) ? '0 : cur_year + 1'b1;
                        end
                        else
                            cur_month++;
                    end
                    else
                        cur_day++;
                end
            end
        end
        res.hour          = cur_hour;
        res.minute        = cur_minute;
        res.second        = cur_second;
        res.day           = cur_day;
        res.month         = cur_month;
        res.year          = cur_year;
        res.alarm_match   = (cur_hour == alarm_hour) && (cur_minute == alarm_minute)
                            && (cur_second == alarm_second);
        res.date_advanced = rolled;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rtc_out_t want;
        if (!rst_n)
        begin
            cur_hour     = '0;
            cur_minute   = '0;
            cur_second   = '0;
            cur_day      = RESET_DAY;
            cur_month    = RESET_MONTH;
            cur_year     = RESET_YEAR;
            alarm_hour   = '0;
            alarm_minute = '0;
            alarm_second = '0;
            results_due.delete();
            error_count  = 0;
            pending      = 0;
            checked      = 0;
            rollovers    = 0;
            alarm_hits   = 0;
        end
        else
        begin
            // results leave from the head before new inputs join at the tail
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                    report_mismatch("result with no transfer waiting", out_data.hour, 0);
                else
                begin
                    want = results_due.pop_front();
                    checked++;
                    if (out_data.hour !== want.hour)
                        report_mismatch("hour", out_data.hour, want.hour);
                    if (out_data.minute !== want.minute)
                        report_mismatch("minute", out_data.minute, want.minute);
                    if (out_data.second !== want.second)
                        report_mismatch("second", out_data.second, want.second);
                    if (out_data.day !== want.day)
                        report_mismatch("day", out_data.day, want.day);
                    if (out_data.month !== want.month)
                        report_mismatch("month", out_data.month, want.month);
                    if (out_data.year !== want.year)
                        report_mismatch("year", out_data.year, want.year);
                    if (out_data.alarm_match !== want.alarm_match)
                        report_mismatch("alarm_match", out_data.alarm_match, want.alarm_match);
                    if (out_data.date_advanced !== want.date_advanced)
                        report_mismatch("date_advanced", out_data.date_advanced,
                                        want.date_advanced);
                    if (want.date_advanced)
                        rollovers++;
                    if (want.alarm_match)
                        alarm_hits++;
                end
            end
            if (in_valid && !in_stall)
                results_due.push_back(step_calendar(in_data));
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_ALARM_HOUR:   alarm_hour   = cfg_wdata[HOUR_W-1:0];
                    CFG_ALARM_MINUTE: alarm_minute = cfg_wdata[MINUTE_W-1:0];
                    CFG_ALARM_SECOND: alarm_second = cfg_wdata[SECOND_W-1:0];
                    default:          ;
                endcase
            end
            pending = results_due.size();
        end
    end

endmodule

// File: tb/sv/tb_rtc_time_calendar_counter.sv
// Testbench top for the calendar counter: clock, reset, alarm programming and
// tick/load stimulus with random gaps and stalls; verdict from the checker.
// Depends on rtc_pkg, rtc_time_calendar_counter and tb_rtc_calendar_checker.
`timescale 1ns / 1ps

module tb_rtc_time_calendar_counter;
    import rtc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_PCT      = 38;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int PHASES        = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    rtc_in_t                in_data;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    rtc_out_t               out_data;
    logic                   cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int error_count;
    int pending;
    int checked;
    int rollovers;
    int alarm_hits;
    int idle_pct = IDLE_PCT;
    int loads_sent;
    int ticks_sent;
    int cycle_count;

    logic [HOUR_W-1:0]   alarm_hour;
    logic [MINUTE_W-1:0] alarm_minute;
    logic [SECOND_W-1:0] alarm_second;

    rtc_time_calendar_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tb_rtc_calendar_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .error_count (error_count),
        .pending     (pending),
        .checked     (checked),
        .rollovers   (rollovers),
        .alarm_hits  (alarm_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
        $display("tb_rtc_time_calendar_counter: errors");
        $finish;
    end

    function automatic rtc_in_t random_item(input rtc_op_t op);
        rtc_in_t     item;
        logic [63:0] bits;
        bits        = {$urandom, $urandom};
        item        = bits[$bits(rtc_in_t)-1:0];
        item.opcode = op;
        return item;
    endfunction

    function automatic rtc_in_t load_item(input int unsigned h, m, s, d, mo, y);
        rtc_in_t item;
        item             = random_item(OP_LOAD);
        item.load_hour   = HOUR_W'(h);
        item.load_minute = MINUTE_W'(m);
        item.load_second = SECOND_W'(s);
        item.load_day    = DAY_W'(d);
        item.load_month  = MONTH_W'(mo);
        item.load_year   = YEAR_W'(y);
        return item;
    endfunction

    // Enter and leave at a falling edge; the caller drives in_valid at the return edge.
    task automatic push_item(input rtc_in_t item);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        if (item.opcode == OP_LOAD)
            loads_sent++;
        else
            ticks_sent++;
    endtask

    task automatic push_load(input int unsigned h, m, s, d, mo, y);
        push_item(load_item(h, m, s, d, mo, y));
    endtask

    task automatic push_tick();
        push_item(random_item(OP_TICK));
    endtask

    // Hold the input until every result is back, then let the pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_alarm(input int unsigned h, m, s);
        alarm_hour   = HOUR_W'(h);
        alarm_minute = MINUTE_W'(m);
        alarm_second = SECOND_W'(s);
        cfg_wen   <= 1'b1;
        // the spare top bit of the hour write must be dropped
        cfg_index <= CFG_ALARM_HOUR;
        cfg_wdata <= {1'($urandom_range(1)), alarm_hour};
        @(negedge clk);
        cfg_index <= CFG_ALARM_MINUTE;
        cfg_wdata <= alarm_minute;
        @(negedge clk);
        cfg_index <= CFG_ALARM_SECOND;
        cfg_wdata <= alarm_second;
        @(negedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Mostly loads just before midnight near month ends, then tick runs.
    task automatic run_random(input int n_items);
        int          sent;
        int unsigned pick;
        int unsigned ticks;
        int unsigned h, m, s, d, mo, y;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                h = ($urandom_range(3) != 0) ? 23 : $urandom_range(23);
                m = ($urandom_range(3) != 0) ? 59 : $urandom_range(59);
                s = $urandom_range(59, 40);
                if ($urandom_range(4) == 0)
                begin
                    // land on the alarm time within a few ticks
                    h = alarm_hour;
                    m = alarm_minute;
                    s = alarm_second;
                    s = s - (($urandom_range(3) < s) ? $urandom_range(3) : 0);
                end
                case ($urandom_range(4))
                    0:       d = 28;
                    1:       d = 29;
                    2:       d = 30;
                    3:       d = 31;
                    default: d = $urandom_range(31, 1);
                endcase
                mo = $urandom_range(12, 1);
                case ($urandom_range(5))
                    0:       y = $urandom_range(9999);
                    1:       y = 4 * $urandom_range(2499);
                    2:       y = 100 * $urandom_range(99);
                    3:       y = 400 * $urandom_range(24);
                    4:       y = 9999;
                    default: y = $urandom_range(16383);
                endcase
                push_load(h, m, s, d, mo, y);
                ticks = $urandom_range(30, 1);
            end
            else if (pick < 90)
            begin
                push_item(random_item(OP_LOAD));
                ticks = $urandom_range(8);
            end
            else
                ticks = $urandom_range(60, 1);
            if (pick < 90)
                sent++;
            repeat (ticks)
            begin
                push_tick();
                sent++;
            end
        end
    endtask

    initial
    begin
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_wen    = 1'b0;
        cfg_index  = CFG_ALARM_HOUR;
        cfg_wdata  = '0;
        rst_n      = 1'b0;
        loads_sent = 0;
        ticks_sent = 0;
        alarm_hour   = '0;
        alarm_minute = '0;
        alarm_second = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset state and reset alarm
        push_tick();
        push_load(0, 0, 0, 1, 1, 2000);
        wait_idle();

        set_alarm(23, 59, 59);
        push_load(23, 59, 58, 28, 2, 1900);
        push_tick();
        push_tick();
        push_load(23, 59, 59, 28, 2, 2000);
        push_tick();
        push_load(23, 59, 59, 29, 2, 2024);
        push_tick();
        push_load(23, 59, 59, 28, 2, 2023);
        push_tick();
        push_load(23, 59, 59, 31, 12, 9999);
        push_tick();
        push_load(23, 59, 59, 30, 4, 2023);
        push_tick();
        // time fields out of range, day and month zero
        push_load(31, 63, 63, 0, 0, 16383);
        push_tick();
        push_load(23, 59, 59, 31, 15, 16383);
        push_tick();
        push_load(23, 59, 59, 31, 0, 2001);
        push_tick();
        push_load(23, 59, 59, 31, 2, 2023);
        push_tick();
        push_load(10, 63, 59, 15, 6, 2024);
        push_tick();
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       set_alarm(0, 0, 0);
                1:       set_alarm(31, 63, 63);
                3:       set_alarm(23, 59, 59);
                default: set_alarm($urandom_range(23), $urandom_range(59), $urandom_range(59));
            endcase
            // one phase runs with no gaps or stalls at all
            idle_pct = (ph == 1) ? 0 : IDLE_PCT;
            if (ph == 2)
            begin
                run_random(RANDOM_ITEMS / PHASES / 2);
                wait_idle();
                run_random(RANDOM_ITEMS / PHASES / 2);
            end
            else
                run_random(RANDOM_ITEMS / PHASES);
            wait_idle();
        end
        idle_pct = IDLE_PCT;

        $display("sent %0d loads and %0d ticks under %0d alarm settings",
                 loads_sent, ticks_sent, PHASES + 2);
        $display("checked %0d results: %0d date rollovers, %0d alarm hits, %0d mismatches",
                 checked, rollovers, alarm_hits, error_count);
        if (error_count == 0 && pending == 0)
            $display("tb_rtc_time_calendar_counter: clean");
        else
            $display("tb_rtc_time_calendar_counter: errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rtc_pkg.sv
hw/rtl/rtc_time_calendar_counter.sv
tb/sv/tb_rtc_calendar_checker.sv
tb/sv/tb_rtc_time_calendar_counter.sv
